// ===== rtl/fpr_pkg.sv =====
// ----------------------------------------------------------------------------
// fpr_pkg
// shared types and constants of the framed packet receiver
// ----------------------------------------------------------------------------
package fpr_pkg;

  // register map, index is paddr[3:2]
  typedef enum logic [1:0] {
    REG_LEAD_A    = 2'd0,
    REG_LEAD_B    = 2'd1,
    REG_TIMEOUT   = 2'd2,
    REG_LEN_LIMIT = 2'd3
  } reg_idx_e;

  // result status codes
  typedef enum logic [2:0] {
    ST_BODY     = 3'd0,
    ST_DONE     = 3'd1,
    ST_HDR_ERR  = 3'd2,
    ST_LEN_ERR  = 3'd3,
    ST_SUM_ERR  = 3'd4
  } status_e;

  localparam logic [7:0]  LeadAReset    = 8'd170;
  localparam logic [7:0]  LeadBReset    = 8'd85;
  localparam logic [31:0] TimeoutReset  = 32'd1000;
  localparam logic [15:0] LenLimitReset = 16'd1024;

  // header byte positions
  localparam logic [3:0] PosCmdLo   = 4'd2;
  localparam logic [3:0] PosCmdHi   = 4'd3;
  localparam logic [3:0] PosLenLo   = 4'd4;
  localparam logic [3:0] PosLenHi   = 4'd5;
  localparam logic [3:0] PosSum0    = 4'd6;
  localparam logic [3:0] PosSum1    = 4'd7;
  localparam logic [3:0] PosSum2    = 4'd8;
  localparam logic [3:0] PosSum3    = 4'd9;
  localparam logic [3:0] PosChkLo   = 4'd10;
  localparam logic [3:0] PosChkHi   = 4'd11;

  localparam logic [16:0] HeaderBytes = 17'd12;

  typedef struct packed {
    logic [7:0]  lead_a;
    logic [7:0]  lead_b;
    logic [31:0] timeout_ms;
    logic [15:0] len_limit;
  } cfg_t;

  typedef struct packed {
    status_e     status;
    logic        byte_valid;
    logic [7:0]  body_byte;
    logic [15:0] command_code;
    logic [15:0] body_length;
  } result_t;

endpackage

// ===== rtl/fpr_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// fpr_cfg_regs
// apb-style configuration registers of the framed packet receiver
// ----------------------------------------------------------------------------
module fpr_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output fpr_pkg::cfg_t cfg_o
);

  fpr_pkg::cfg_t      cfg_q;
  fpr_pkg::reg_idx_e  idx;
  logic               wr_en;

  assign idx    = fpr_pkg::reg_idx_e'(paddr[3:2]);
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lead_a     <= fpr_pkg::LeadAReset;
      cfg_q.lead_b     <= fpr_pkg::LeadBReset;
      cfg_q.timeout_ms <= fpr_pkg::TimeoutReset;
      cfg_q.len_limit  <= fpr_pkg::LenLimitReset;
    end else if (wr_en) begin
      case (idx)
        fpr_pkg::REG_LEAD_A:    cfg_q.lead_a     <= pwdata[7:0];
        fpr_pkg::REG_LEAD_B:    cfg_q.lead_b     <= pwdata[7:0];
        fpr_pkg::REG_TIMEOUT:   cfg_q.timeout_ms <= pwdata;
        fpr_pkg::REG_LEN_LIMIT: cfg_q.len_limit  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      fpr_pkg::REG_LEAD_A:    prdata = {24'd0, cfg_q.lead_a};
      fpr_pkg::REG_LEAD_B:    prdata = {24'd0, cfg_q.lead_b};
      fpr_pkg::REG_TIMEOUT:   prdata = cfg_q.timeout_ms;
      fpr_pkg::REG_LEN_LIMIT: prdata = {16'd0, cfg_q.len_limit};
      default:                prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/fpr_parser.sv =====
// ----------------------------------------------------------------------------
// fpr_parser
// frame state and per-byte decode: sync hunt, header, body, checks
// ----------------------------------------------------------------------------
module fpr_parser (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  logic [7:0]      rx_byte_i,
  input  logic [31:0]     now_ms_i,
  input  fpr_pkg::cfg_t   cfg_i,
  output logic            has_result_o,
  output fpr_pkg::result_t result_o
);

  logic [16:0] count_q, count_d;
  logic [31:0] start_q, start_d;
  logic [15:0] cmd_q, cmd_d;
  logic [15:0] len_q, len_d;
  logic [15:0] hsum_q, hsum_d;
  logic [7:0]  chk_lo_q, chk_lo_d;
  logic [31:0] exp_sum_q, exp_sum_d;
  logic [31:0] run_sum_q, run_sum_d;

  logic [32:0] age;
  logic        expired;
  logic [16:0] count;
  logic [3:0]  pos;
  logic [15:0] got_chk;
  logic [16:0] count_inc;

  // frame age, bit 32 set when time ran backwards
  assign age     = {1'b0, now_ms_i} - {1'b0, start_q};
  assign expired = (count_q != 17'd0) && (start_q != 32'd0) &&
                   (age[32] || (age[31:0] > cfg_i.timeout_ms));
  assign count     = expired ? 17'd0 : count_q;
  assign pos       = count[3:0];
  assign got_chk   = {rx_byte_i, chk_lo_q};
  assign count_inc = count + 17'd1;

  always_comb begin
    count_d   = count;
    start_d   = expired ? 32'd0 : start_q;
    cmd_d     = cmd_q;
    len_d     = len_q;
    hsum_d    = hsum_q;
    chk_lo_d  = chk_lo_q;
    exp_sum_d = exp_sum_q;
    run_sum_d = run_sum_q;

    has_result_o          = 1'b0;
    result_o.status       = fpr_pkg::ST_BODY;
    result_o.byte_valid   = 1'b0;
    result_o.body_byte    = 8'd0;
    result_o.command_code = cmd_q;
    result_o.body_length  = len_q;

    if (count == 17'd0) begin
      if (rx_byte_i == cfg_i.lead_a) begin
        count_d = 17'd1;
        start_d = now_ms_i;
        hsum_d  = {8'd0, rx_byte_i};
      end
    end else if (count == 17'd1) begin
      if (rx_byte_i == cfg_i.lead_b) begin
        count_d = 17'd2;
        hsum_d  = hsum_q + {8'd0, rx_byte_i};
      end else begin
        count_d = 17'd0;
        start_d = 32'd0;
      end
    end else if (count < fpr_pkg::HeaderBytes) begin
      count_d = count_inc;
      if (pos < fpr_pkg::PosChkLo) begin
        hsum_d = hsum_q + {8'd0, rx_byte_i};
      end
      case (pos)
        fpr_pkg::PosCmdLo: cmd_d     = {8'd0, rx_byte_i};
        fpr_pkg::PosCmdHi: cmd_d     = {rx_byte_i, cmd_q[7:0]};
        fpr_pkg::PosLenLo: len_d     = {8'd0, rx_byte_i};
        fpr_pkg::PosLenHi: len_d     = {rx_byte_i, len_q[7:0]};
        fpr_pkg::PosSum0:  exp_sum_d = {24'd0, rx_byte_i};
        fpr_pkg::PosSum1:  exp_sum_d = {16'd0, rx_byte_i, exp_sum_q[7:0]};
        fpr_pkg::PosSum2:  exp_sum_d = {8'd0, rx_byte_i, exp_sum_q[15:0]};
        fpr_pkg::PosSum3:  exp_sum_d = {rx_byte_i, exp_sum_q[23:0]};
        fpr_pkg::PosChkLo: chk_lo_d  = rx_byte_i;
        default: ;
      endcase
      // last header byte: checksum, length limit, empty body
      if (pos == fpr_pkg::PosChkHi) begin
        run_sum_d = 32'd0;
        if (got_chk != hsum_q) begin
          has_result_o    = 1'b1;
          result_o.status = fpr_pkg::ST_HDR_ERR;
        end else if (len_q > cfg_i.len_limit) begin
          has_result_o    = 1'b1;
          result_o.status = fpr_pkg::ST_LEN_ERR;
        end else if (len_q == 16'd0) begin
          has_result_o    = 1'b1;
          result_o.status = fpr_pkg::ST_DONE;
        end
        if (has_result_o) begin
          count_d = 17'd0;
          start_d = 32'd0;
        end
      end
    end else begin
      run_sum_d           = run_sum_q + {24'd0, rx_byte_i};
      count_d             = count_inc;
      has_result_o        = 1'b1;
      result_o.byte_valid = 1'b1;
      result_o.body_byte  = rx_byte_i;
      if ((count_inc >= fpr_pkg::HeaderBytes) &&
          ((count_inc - fpr_pkg::HeaderBytes) == {1'b0, len_q})) begin
        result_o.status = (run_sum_d == exp_sum_q) ? fpr_pkg::ST_DONE : fpr_pkg::ST_SUM_ERR;
        count_d         = 17'd0;
        start_d         = 32'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= 17'd0;
      start_q   <= 32'd0;
      cmd_q     <= 16'd0;
      len_q     <= 16'd0;
      hsum_q    <= 16'd0;
      chk_lo_q  <= 8'd0;
      exp_sum_q <= 32'd0;
      run_sum_q <= 32'd0;
    end else if (step_i) begin
      count_q   <= count_d;
      start_q   <= start_d;
      cmd_q     <= cmd_d;
      len_q     <= len_d;
      hsum_q    <= hsum_d;
      chk_lo_q  <= chk_lo_d;
      exp_sum_q <= exp_sum_d;
      run_sum_q <= run_sum_d;
    end
  end

endmodule

// ===== rtl/framed_packet_receiver.sv =====
// ----------------------------------------------------------------------------
// framed_packet_receiver
// byte-stream frame receiver: sync, header checks, body forwarding
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid_i / in_ready_o) carries one received byte and its
//   millisecond timestamp per transaction. output channel (out_valid_o /
//   out_ready_i) carries at most one result per input transaction: a body
//   byte, a frame completion or one of the error codes.
//   configuration goes through the apb-style port, one 32-bit register every
//   four bytes; write it only while the block is idle.
// timing
//   an accepted byte lands in the input register, is decoded from there and
//   its result is loaded into the output register, which drives output valid.
//   one byte per cycle sustained while the receiver takes the results or the
//   bytes make none; the decode is a single pass of add and compare logic on
//   the frame state.
// reset
//   frame state clears to hunting, registers take their default values, both
//   pipeline registers empty. no clearing pass, the block is ready at once.
// stall
//   when the receiver holds off, the result waits in the output register and
//   one more byte is still taken into the input register; bytes that produce
//   no result keep flowing past a full output register.
// ----------------------------------------------------------------------------
module framed_packet_receiver (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  input  logic [31:0] now_ms_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic        byte_valid_o,
  output logic [7:0]  body_byte_o,
  output logic [15:0] command_code_o,
  output logic [15:0] body_length_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  fpr_pkg::cfg_t    cfg;
  fpr_pkg::result_t result;
  fpr_pkg::result_t out_q;
  logic             has_result;

  // input register
  logic        in_valid_q;
  logic [7:0]  rx_byte_q;
  logic [31:0] now_ms_q;

  logic        out_valid_q;
  logic        advance;

  fpr_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  fpr_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .rx_byte_i    (rx_byte_q),
    .now_ms_i     (now_ms_q),
    .cfg_i        (cfg),
    .has_result_o (has_result),
    .result_o     (result)
  );

  // a buffered byte moves on when its result has room, or when it has none
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i || !has_result);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      rx_byte_q <= rx_byte_i;
      now_ms_q  <= now_ms_i;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && has_result) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && has_result) begin
      out_q <= result;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_q.status;
  assign byte_valid_o   = out_q.byte_valid;
  assign body_byte_o    = out_q.body_byte;
  assign command_code_o = out_q.command_code;
  assign body_length_o  = out_q.body_length;

  // checks

  // a result without a body byte always carries a header status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_valid_o |->
      (status_o == fpr_pkg::ST_DONE) || (status_o == fpr_pkg::ST_HDR_ERR) ||
      (status_o == fpr_pkg::ST_LEN_ERR))
    else $error("header result with unexpected status");

  // a plain body result always forwards its byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == fpr_pkg::ST_BODY) |-> byte_valid_o)
    else $error("body status without body byte");

  // a draining output lets the buffered byte through and frees the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_ready_i |-> advance && in_ready_o)
    else $error("pipeline stalled with a free output slot");

  // a result is only loaded from a decoded byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(out_valid_q) && out_valid_q |-> $past(advance && has_result))
    else $error("result appeared without a decoded byte");

endmodule

// ===== tb/tb_framed_packet_receiver.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_framed_packet_receiver
// self-checking bench for the framed packet receiver: frame sync, header
// checks, body forwarding, timeouts and back-pressure on both channels
// ----------------------------------------------------------------------------

// frame tracker: mirrors the receiver's frame state and register copies,
// predicts the result of every accepted byte and checks the results in order
class frame_scoreboard;
  logic [7:0]  lead_a;
  logic [7:0]  lead_b;
  logic [31:0] timeout_ms;
  logic [15:0] len_limit;

  logic [16:0] frame_pos;
  logic [31:0] start_ms;
  logic [15:0] cmd_hold;
  logic [15:0] len_hold;
  logic [15:0] hdr_sum;
  logic [7:0]  chk_low;
  logic [31:0] body_sum_want;
  logic [31:0] body_sum_got;

  fpr_pkg::result_t pending[$];
  int unsigned failures;
  int unsigned time_drops;
  int unsigned status_tally[5];

  function new();
    lead_a        = fpr_pkg::LeadAReset;
    lead_b        = fpr_pkg::LeadBReset;
    timeout_ms    = fpr_pkg::TimeoutReset;
    len_limit     = fpr_pkg::LenLimitReset;
    frame_pos     = '0;
    start_ms      = '0;
    cmd_hold      = '0;
    len_hold      = '0;
    hdr_sum       = '0;
    chk_low       = '0;
    body_sum_want = '0;
    body_sum_got  = '0;
    failures      = 0;
    time_drops    = 0;
    foreach (status_tally[i]) status_tally[i] = 0;
  endfunction

  function void set_register(fpr_pkg::reg_idx_e idx, logic [31:0] value);
    case (idx)
      fpr_pkg::REG_LEAD_A:    lead_a = value[7:0];
      fpr_pkg::REG_LEAD_B:    lead_b = value[7:0];
      fpr_pkg::REG_TIMEOUT:   timeout_ms = value;
      fpr_pkg::REG_LEN_LIMIT: len_limit = value[15:0];
      default: ;
    endcase
  endfunction

  function logic [31:0] register_value(fpr_pkg::reg_idx_e idx);
    case (idx)
      fpr_pkg::REG_LEAD_A:    return {24'd0, lead_a};
      fpr_pkg::REG_LEAD_B:    return {24'd0, lead_b};
      fpr_pkg::REG_TIMEOUT:   return timeout_ms;
      fpr_pkg::REG_LEN_LIMIT: return {16'd0, len_limit};
      default:                return '0;
    endcase
  endfunction

  function void queue_result(fpr_pkg::status_e st, logic carries, logic [7:0] b);
    fpr_pkg::result_t r;
    r.status       = st;
    r.byte_valid   = carries;
    r.body_byte    = carries ? b : 8'h00;
    r.command_code = cmd_hold;
    r.body_length  = len_hold;
    pending.push_back(r);
    if (st != fpr_pkg::ST_BODY) begin
      frame_pos = '0;
      start_ms  = '0;
    end
  endfunction

  function void note_byte(logic [7:0] b, logic [31:0] now);
    logic [15:0] chk;
    // stale or time-reversed partial frame goes away before the byte is seen
    if (frame_pos != 0 && start_ms != 0 &&
        (now < start_ms || now - start_ms > timeout_ms)) begin
      frame_pos = '0;
      start_ms  = '0;
      time_drops++;
    end
    if (frame_pos == 0) begin
      if (b == lead_a) begin
        frame_pos = 17'd1;
        start_ms  = now;
        hdr_sum   = {8'h00, b};
      end
      return;
    end
    if (frame_pos == 1) begin
      if (b == lead_b) begin
        frame_pos = 17'd2;
        hdr_sum   = hdr_sum + 16'(b);
      end else begin
        frame_pos = '0;
        start_ms  = '0;
      end
      return;
    end
    if (frame_pos < fpr_pkg::HeaderBytes) begin
      if (frame_pos < 17'(fpr_pkg::PosChkLo)) hdr_sum = hdr_sum + 16'(b);
      case (frame_pos[3:0])
        fpr_pkg::PosCmdLo: cmd_hold[7:0]        = b;
        fpr_pkg::PosCmdHi: cmd_hold[15:8]       = b;
        fpr_pkg::PosLenLo: len_hold[7:0]        = b;
        fpr_pkg::PosLenHi: len_hold[15:8]       = b;
        fpr_pkg::PosSum0:  body_sum_want[7:0]   = b;
        fpr_pkg::PosSum1:  body_sum_want[15:8]  = b;
        fpr_pkg::PosSum2:  body_sum_want[23:16] = b;
        fpr_pkg::PosSum3:  body_sum_want[31:24] = b;
        fpr_pkg::PosChkLo: chk_low              = b;
        default: ;
      endcase
      frame_pos = frame_pos + 17'd1;
      if (frame_pos == fpr_pkg::HeaderBytes) begin
        chk          = {b, chk_low};
        body_sum_got = '0;
        if (chk != hdr_sum) queue_result(fpr_pkg::ST_HDR_ERR, 1'b0, b);
        else if (len_hold > len_limit) queue_result(fpr_pkg::ST_LEN_ERR, 1'b0, b);
        else if (len_hold == 0) queue_result(fpr_pkg::ST_DONE, 1'b0, b);
      end
      return;
    end
    body_sum_got = body_sum_got + 32'(b);
    frame_pos    = frame_pos + 17'd1;
    if (frame_pos - fpr_pkg::HeaderBytes == 17'(len_hold))
      queue_result((body_sum_got == body_sum_want) ? fpr_pkg::ST_DONE : fpr_pkg::ST_SUM_ERR,
                   1'b1, b);
    else
      queue_result(fpr_pkg::ST_BODY, 1'b1, b);
  endfunction

  function void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      failures++;
      $display("%0t: %s mismatch, expected %0h got %0h", $time, what, want, got);
    end
  endfunction

  function void check_result(fpr_pkg::result_t got);
    fpr_pkg::result_t want;
    if (pending.size() == 0) begin
      failures++;
      $display("%0t: result with nothing expected, status expected none got %0d",
               $time, got.status);
      return;
    end
    want = pending.pop_front();
    status_tally[want.status]++;
    check_field("status", 32'(want.status), 32'(got.status));
    check_field("byte_valid", 32'(want.byte_valid), 32'(got.byte_valid));
    check_field("body_byte", 32'(want.body_byte), 32'(got.body_byte));
    check_field("command_code", 32'(want.command_code), 32'(got.command_code));
    check_field("body_length", 32'(want.body_length), 32'(got.body_length));
  endfunction
endclass

module tb_framed_packet_receiver;

  // ways a generated frame can be spoiled
  typedef enum {
    FAULT_NONE,
    FAULT_BODY_SUM,
    FAULT_HDR_SUM,
    FAULT_LEN,
    FAULT_LEAD_B,
    FAULT_LATE,
    FAULT_EDGE,
    FAULT_BACK
  } frame_fault_e;

  localparam int unsigned PhaseCount  = 8;
  localparam int unsigned PhaseItems  = 180;
  localparam int unsigned LongHold    = 300;
  localparam int unsigned SettleTicks = 8;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // input channel
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i  = 8'h00;
  logic [31:0] now_ms_i   = 32'h0;

  // output channel
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  status_o;
  logic        byte_valid_o;
  logic [7:0]  body_byte_o;
  logic [15:0] command_code_o;
  logic [15:0] body_length_o;

  // register port
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [3:0]  paddr   = 4'h0;
  logic [31:0] pwdata  = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  // shared between the stimulus and the result sink
  frame_scoreboard sb = new();
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          long_hold_req  = 1'b0;

  // stimulus bookkeeping
  logic [31:0] cur_ms      = 32'h0;
  bit          freeze_ms   = 1'b0;
  int unsigned frame_items = 0;
  int unsigned noise_items = 0;

  always #6 clk_i = ~clk_i;

  framed_packet_receiver dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .rx_byte_i      (rx_byte_i),
    .now_ms_i       (now_ms_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .byte_valid_o   (byte_valid_o),
    .body_byte_o    (body_byte_o),
    .command_code_o (command_code_o),
    .body_length_o  (body_length_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // offer one byte and wait for its transaction; valid stays high across
  // back-to-back transactions and only drops for a sender gap
  task automatic send_byte(input logic [7:0] b, input logic [31:0] ms);
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    now_ms_i   <= ms;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_byte(b, ms);
  endtask

  // stop offering, let every expected result come out, then give bytes that
  // make no result time to clear the two pipeline registers
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SettleTicks) @(posedge clk_i);
  endtask

  // register write: setup cycle, then access cycle until pready
  task automatic write_reg(input fpr_pkg::reg_idx_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_register(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // register read, compared against the tracker's copy
  task automatic read_reg(input fpr_pkg::reg_idx_e idx);
    logic [31:0] want;
    want    = sb.register_value(idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want) begin
      sb.failures++;
      $display("%0t: register %s readback, expected %0h got %0h",
               $time, idx.name(), want, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [7:0] a, input logic [7:0] b,
                              input logic [31:0] tmo, input logic [15:0] lim);
    write_reg(fpr_pkg::REG_LEAD_A, {24'd0, a});
    write_reg(fpr_pkg::REG_LEAD_B, {24'd0, b});
    write_reg(fpr_pkg::REG_TIMEOUT, tmo);
    write_reg(fpr_pkg::REG_LEN_LIMIT, {16'd0, lim});
    read_reg(fpr_pkg::REG_LEAD_A);
    read_reg(fpr_pkg::REG_LEAD_B);
    read_reg(fpr_pkg::REG_TIMEOUT);
    read_reg(fpr_pkg::REG_LEN_LIMIT);
  endtask

  // build one frame from the current lead bytes and send it byte by byte;
  // the fault decides which part gets spoiled and how time jumps at a random byte
  task automatic send_frame(input logic [15:0] cmd, input logic [15:0] len,
                            input frame_fault_e fault);
    logic [7:0]        fb[$];
    logic [7:0]        second;
    logic [7:0]        bb;
    logic [15:0]       hsum;
    logic [31:0]       bsum;
    logic [31:0]       t0;
    longint unsigned   late_ms;
    int unsigned       cut;
    bsum = '0;
    // second lead byte: right one, or a wrong one that may even equal the first
    second = sb.lead_b;
    if (fault == FAULT_LEAD_B) begin
      if (sb.lead_a != sb.lead_b && $urandom_range(0, 1) == 1) second = sb.lead_a;
      else second = sb.lead_b ^ 8'($urandom_range(1, 255));
    end
    fb.push_back(sb.lead_a);
    fb.push_back(second);
    fb.push_back(cmd[7:0]);
    fb.push_back(cmd[15:8]);
    fb.push_back(len[7:0]);
    fb.push_back(len[15:8]);
    // body sum bytes are filled in once the body is known
    repeat (4) fb.push_back(8'h00);
    // header-rejected frames carry no body
    if (fault != FAULT_HDR_SUM && fault != FAULT_LEN) begin
      for (int i = 0; i < int'(len); i++) begin
        bb   = 8'($urandom_range(0, 255));
        bsum = bsum + 32'(bb);
      end
    end
    if (fault == FAULT_BODY_SUM) bsum = bsum ^ ($urandom | 32'h1);
    fb[6] = bsum[7:0];
    fb[7] = bsum[15:8];
    fb[8] = bsum[23:16];
    fb[9] = bsum[31:24];
    hsum = '0;
    foreach (fb[i]) hsum = hsum + 16'(fb[i]);
    if (fault == FAULT_HDR_SUM) hsum = hsum + 16'($urandom_range(1, 65535));
    fb.push_back(hsum[7:0]);
    fb.push_back(hsum[15:8]);
    // regenerate the body with new bytes and a new sum, and keep the bytes in
    // the frame queue directly instead of replaying the byte stream
    if (fault != FAULT_HDR_SUM && fault != FAULT_LEN && len != 0) begin
      // rebuild: new body bytes, then fix the sum field and header check
      bsum = '0;
      for (int i = 0; i < int'(len); i++) begin
        bb   = 8'($urandom_range(0, 255));
        bsum = bsum + 32'(bb);
        fb.push_back(bb);
      end
      if (fault == FAULT_BODY_SUM) bsum = bsum ^ ($urandom | 32'h1);
      fb[6] = bsum[7:0];
      fb[7] = bsum[15:8];
      fb[8] = bsum[23:16];
      fb[9] = bsum[31:24];
      hsum = '0;
      for (int i = 0; i < 10; i++) hsum = hsum + 16'(fb[i]);
      fb[10] = hsum[7:0];
      fb[11] = hsum[15:8];
    end
    cut = $urandom_range(1, fb.size() - 1);
    t0  = cur_ms;
    for (int i = 0; i < fb.size(); i++) begin
      // mostly the same millisecond, now and then a small step
      if (i != 0 && !freeze_ms)
        cur_ms = cur_ms + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
      if (i == cut) begin
        late_ms = longint'(t0) + longint'(sb.timeout_ms);
        case (fault)
          FAULT_LATE: if (late_ms < 64'hFFFF_FFFF) cur_ms = 32'(late_ms + 1);
          FAULT_EDGE: if (late_ms <= 64'hFFFF_FFFF) cur_ms = 32'(late_ms);
          FAULT_BACK: if (t0 != 0) cur_ms = $urandom_range(0, t0 - 1);
          default: ;
        endcase
      end
      send_byte(fb[i], cur_ms);
    end
    frame_items += fb.size();
  endtask

  // one random burst: mostly well-formed frames with random content, the
  // rest spoiled frames and line noise
  task automatic random_traffic();
    int unsigned  r;
    int unsigned  cap;
    logic [15:0]  len;
    frame_fault_e fault;
    r = $urandom_range(0, 99);
    if (r >= 92) begin
      repeat ($urandom_range(1, 6)) begin
        send_byte(8'($urandom_range(0, 255)), cur_ms);
        noise_items++;
      end
      return;
    end
    // frame start time: zero disables the age check, large values exercise
    // the upper time bits and wrap-around
    case ($urandom_range(0, 19))
      0:       cur_ms = 32'h0;
      1, 2:    cur_ms = $urandom;
      3:       cur_ms = 32'hFFFF_FFFF - $urandom_range(0, 40);
      default: ;
    endcase
    if      (r < 55) fault = FAULT_NONE;
    else if (r < 63) fault = FAULT_BODY_SUM;
    else if (r < 69) fault = FAULT_HDR_SUM;
    else if (r < 75) fault = FAULT_LEN;
    else if (r < 80) fault = FAULT_LEAD_B;
    else if (r < 85) fault = FAULT_LATE;
    else if (r < 88) fault = FAULT_EDGE;
    else             fault = FAULT_BACK;
    if (fault == FAULT_LEN && sb.len_limit == 16'hFFFF) fault = FAULT_HDR_SUM;
    cap = (sb.len_limit < 24) ? sb.len_limit : 24;
    case (fault)
      FAULT_HDR_SUM: len = 16'($urandom_range(0, 65535));
      FAULT_LEN:     len = ($urandom_range(0, 1) == 1) ? sb.len_limit + 16'd1 :
                           16'($urandom_range(sb.len_limit + 1, 65535));
      default: begin
        // body exactly at the limit now and then
        if (sb.len_limit <= 64 && $urandom_range(0, 9) == 0) len = sb.len_limit;
        else len = 16'($urandom_range(0, cap));
      end
    endcase
    send_frame(16'($urandom_range(0, 65535)), len, fault);
  endtask

  // result sink: checks every output transaction and owns out_ready_i,
  // including the long hold-off that backs the block up into its input
  initial begin : result_sink
    int unsigned      hold_left;
    fpr_pkg::result_t got;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        got.status       = fpr_pkg::status_e'(status_o);
        got.byte_valid   = byte_valid_o;
        got.body_byte    = body_byte_o;
        got.command_code = command_code_o;
        got.body_length  = body_length_o;
        sb.check_result(got);
      end
      if (long_hold_req) begin
        hold_left     = LongHold;
        long_hold_req = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // main sequence: reset, directed frames, then one random phase per
  // register setting with the idle pattern rotating through the phases
  initial begin : stimulus
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values of the registers
    read_reg(fpr_pkg::REG_LEAD_A);
    read_reg(fpr_pkg::REG_LEAD_B);
    read_reg(fpr_pkg::REG_TIMEOUT);
    read_reg(fpr_pkg::REG_LEN_LIMIT);

    // directed: empty body with all-ones command at time zero (age check
    // off), then a one-byte body with a bad body sum at the top of time
    freeze_ms = 1'b1;
    cur_ms    = 32'h0;
    send_frame(16'hFFFF, 16'd0, FAULT_NONE);
    cur_ms    = 32'hFFFF_FFFF;
    send_frame(16'h0000, 16'd1, FAULT_BODY_SUM);
    freeze_ms = 1'b0;

    for (int phase = 0; phase < PhaseCount; phase++) begin
      // sender pauses until every expected result is back before each write
      drain_results();
      case (phase)
        0: program_regs(fpr_pkg::LeadAReset, fpr_pkg::LeadBReset,
                        fpr_pkg::TimeoutReset, fpr_pkg::LenLimitReset);
        1: program_regs(8'h00, 8'hFF, 32'h0, 16'h0);
        2: program_regs(8'hFF, 8'h00, 32'hFFFF_FFFF, 16'hFFFF);
        3: program_regs(8'h7E, 8'h7E, 32'd37, 16'd16);
        4: program_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        $urandom_range(5, 200), 16'($urandom_range(0, 40)));
        5: program_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        $urandom, 16'($urandom_range(0, 65535)));
        6: program_regs(8'h3C, 8'hC3, 32'd500, 16'hFFFF);
        default:
           program_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        $urandom_range(0, 20), 16'($urandom_range(0, 1024)));
      endcase
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      // long receiver hold-off while a long body keeps coming in
      if (phase == 0 || phase == 6) begin
        long_hold_req = 1'b1;
        send_frame(16'($urandom_range(0, 65535)), 16'd60, FAULT_NONE);
      end
      while (frame_items < PhaseItems * (phase + 1)) random_traffic();
    end
    drain_results();

    $display("covered %0d frame bytes and %0d noise bytes over %0d register settings",
             frame_items, noise_items, PhaseCount);
    $display("results: %0d body, %0d done, %0d hdr, %0d len, %0d sum err; %0d aged out",
             sb.status_tally[fpr_pkg::ST_BODY], sb.status_tally[fpr_pkg::ST_DONE],
             sb.status_tally[fpr_pkg::ST_HDR_ERR], sb.status_tally[fpr_pkg::ST_LEN_ERR],
             sb.status_tally[fpr_pkg::ST_SUM_ERR], sb.time_drops);
    if (sb.failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog far beyond the slowest correct run
  initial begin : watchdog
    #5_000_000;
    $display("run timed out with %0d results outstanding", sb.pending.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
